@@ sv/cesc_pkg.sv @@
// Shared types, codes and character helpers for the C escape decoder.
`default_nettype none

package cesc_pkg;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_HEX   = 2'd2,
        MODE_OCT   = 2'd3
    } esc_mode_t;

    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_X      = 8'h78;

    // Up to two decoded bytes from one source byte; count is 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] b1;
        logic [7:0] b0;
    } result_pair_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // {hit, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39)
            r = {1'b1, 4'(b - 8'h30)};
        else if (b >= 8'h61 && b <= 8'h66)
            r = {1'b1, 4'(b - 8'h57)};
        else if (b >= 8'h41 && b <= 8'h46)
            r = {1'b1, 4'(b - 8'h37)};
        return r;
    endfunction

    // {hit, value}
    function automatic logic [8:0] simple_escape(input logic [7:0] b);
        logic [8:0] r;
        r = 9'd0;
        case (b)
            8'h5C:   r = {1'b1, 8'h5C};
            8'h61:   r = {1'b1, 8'h07};
            8'h62:   r = {1'b1, 8'h08};
            8'h63:   r = {1'b1, 8'h00};
            8'h65:   r = {1'b1, 8'h1B};
            8'h66:   r = {1'b1, 8'h0C};
            8'h6E:   r = {1'b1, 8'h0A};
            8'h72:   r = {1'b1, 8'h0D};
            8'h74:   r = {1'b1, 8'h09};
            8'h76:   r = {1'b1, 8'h0B};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/c_escape_decoder_unit.sv @@
// Top level of the C string escape decoder.
// Latency: an accepted beat is registered in the input stage, then in the pair queue, before it reaches the output.
// Throughput: one source byte per cycle while the pair queue has a free slot; an item with two
// results holds the output for two beats, and the two-entry pair queue absorbs the difference.
// Reset: rst_n clears escape state, input stage and queue pointers; nothing else to clear.
`default_nettype none

module c_escape_decoder_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] in_byte
    input  wire logic       s_tlast,    // in_last
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,    // [7:0] out_byte
    output logic            m_tlast     // last byte of the current pair
);
    import cesc_pkg::*;

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          in_last_reg;

    logic          adv;
    logic          push;
    result_pair_t  pair;
    queue_status_t q_status;

    // input stage moves into decode whenever the pair queue has a free slot
    assign adv      = in_valid_reg && !q_status.full;
    assign s_tready = !in_valid_reg || !q_status.full;

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    cesc_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .enable  (adv),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .push    (push),
        .pair    (pair)
    );

    cesc_result_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pair     (pair),
        .status   (q_status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    a_status_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty at once");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted beat did not reach the input stage");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> m_tvalid)
        else $error("decoded pair did not show up at the output");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !push)
        else $error("push into a full pair queue");
`endif

endmodule

`default_nettype wire

@@ sv/cesc_decode.sv @@
// Escape state registers and the per-byte decode logic.
`default_nettype none

module cesc_decode (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  enable,
    input  wire logic [7:0]            in_byte,
    input  wire logic                  in_last,
    output logic                       push,
    output cesc_pkg::result_pair_t     pair
);
    import cesc_pkg::*;

    esc_mode_t  mode_reg, mode_next;
    logic [7:0] value_reg, value_next;
    logic [1:0] dcount_reg, dcount_next;

    logic [4:0] hex;
    logic [8:0] simple;
    logic       is_oct;
    logic       pl_push;
    logic       pl_esc;
    logic [1:0] n;
    logic [7:0] r0, r1;

    assign hex     = hex_digit(in_byte);
    assign simple  = simple_escape(in_byte);
    assign is_oct  = (in_byte[7:3] == 5'b00110);
    // plain-text handling of the current byte
    assign pl_push = (in_byte != CHAR_BSLASH);
    assign pl_esc  = (in_byte == CHAR_BSLASH) && !in_last;

    always_comb
    begin
        esc_mode_t  m;
        logic [7:0] v;
        logic [1:0] c;
        m  = mode_reg;
        v  = value_reg;
        c  = dcount_reg;
        n  = 2'd0;
        r0 = in_byte;
        r1 = in_byte;
        unique case (mode_reg)
            MODE_PLAIN:
            begin
                n = {1'b0, pl_push};
                m = pl_esc ? MODE_ESC : MODE_PLAIN;
            end
            MODE_ESC:
            begin
                m = MODE_PLAIN;
                if (simple[8])
                begin
                    n  = 2'd1;
                    r0 = simple[7:0];
                end
                else if (in_byte == CHAR_X)
                begin
                    v = 8'd0;
                    c = 2'd0;
                    if (in_last)
                    begin
                        n  = 2'd1;
                        r0 = CHAR_X;
                    end
                    else
                        m = MODE_HEX;
                end
                else if (is_oct)
                begin
                    v = {5'd0, in_byte[2:0]};
                    c = 2'd1;
                    if (in_last)
                    begin
                        n  = 2'd1;
                        r0 = v;
                    end
                    else
                        m = MODE_OCT;
                end
                else
                    n = 2'd1;
            end
            MODE_HEX:
            begin
                if (hex[4])
                begin
                    v = {value_reg[3:0], hex[3:0]};
                    c = dcount_reg + 2'd1;
                    if (c >= 2'd2 || in_last)
                    begin
                        n  = 2'd1;
                        r0 = v;
                        m  = MODE_PLAIN;
                    end
                end
                else
                begin
                    r0 = (dcount_reg == 2'd0) ? CHAR_X : value_reg;
                    n  = pl_push ? 2'd2 : 2'd1;
                    m  = pl_esc ? MODE_ESC : MODE_PLAIN;
                end
            end
            MODE_OCT:
            begin
                if (is_oct)
                begin
                    v = {value_reg[4:0], in_byte[2:0]};
                    c = dcount_reg + 2'd1;
                    if (c == 2'd3 || in_last)
                    begin
                        n  = 2'd1;
                        r0 = v;
                        m  = MODE_PLAIN;
                    end
                end
                else
                begin
                    r0 = value_reg;
                    n  = pl_push ? 2'd2 : 2'd1;
                    m  = pl_esc ? MODE_ESC : MODE_PLAIN;
                end
            end
            default:
            begin
                m = MODE_PLAIN;
            end
        endcase

        if (m == MODE_PLAIN || in_last)
        begin
            mode_next   = MODE_PLAIN;
            value_next  = 8'd0;
            dcount_next = 2'd0;
        end
        else
        begin
            mode_next   = m;
            value_next  = v;
            dcount_next = c;
        end
    end

    assign push       = enable && (n != 2'd0);
    assign pair.count = n;
    assign pair.b0    = r0;
    assign pair.b1    = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_PLAIN;
            value_reg  <= 8'd0;
            dcount_reg <= 2'd0;
        end
        else if (enable)
        begin
            mode_reg   <= mode_next;
            value_reg  <= value_next;
            dcount_reg <= dcount_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/cesc_result_queue.sv @@
// Two-entry queue of decoded byte pairs, sent out one byte per beat.
`default_nettype none

module cesc_result_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire cesc_pkg::result_pair_t pair,
    output cesc_pkg::queue_status_t     status,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [7:0]                  m_tdata,   // [7:0] out_byte
    output logic                        m_tlast    // last byte of the current pair
);
    import cesc_pkg::*;

    result_pair_t pair_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   cnt_reg;
    logic         phase_reg;

    result_pair_t head;
    logic         beat;
    logic         pop;

    assign head     = pair_reg[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = phase_reg ? head.b1 : head.b0;
    assign m_tlast  = phase_reg || (head.count == 2'd1);
    assign beat     = m_tvalid && m_tready;
    assign pop      = beat && m_tlast;

    assign status.full  = (cnt_reg == 2'd2);
    assign status.empty = (cnt_reg == 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
            pair_reg[wr_ptr_reg] <= pair;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
            if (beat)
                phase_reg <= !m_tlast;
        end
    end

endmodule

`default_nettype wire
